/* src/tcss_pkg.sv */
// ----------------------------------------------------------------------------
// tcss_pkg: shared types and constants of the terminal screen
// Screen geometry, character codes, parser phases and the command word
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package tcss_pkg;

  localparam int unsigned Rows      = 10;
  localparam int unsigned Cols      = 10;
  localparam int unsigned CoordW    = 4;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RowIdxW   = $clog2(Rows);
  localparam int unsigned ColIdxW   = $clog2(Cols);
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 24;

  localparam logic [CoordW-1:0] RowMax = CoordW'(Rows - 1);
  localparam logic [CoordW-1:0] ColMax = CoordW'(Cols - 1);

  localparam logic [CharW-1:0] ChEsc   = 8'h5E;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChB     = "b";
  localparam logic [CharW-1:0] ChC     = "c";
  localparam logic [CharW-1:0] ChD     = "d";
  localparam logic [CharW-1:0] ChE     = "e";
  localparam logic [CharW-1:0] ChH     = "h";
  localparam logic [CharW-1:0] ChI     = "i";
  localparam logic [CharW-1:0] ChL     = "l";
  localparam logic [CharW-1:0] ChO     = "o";
  localparam logic [CharW-1:0] ChR     = "r";
  localparam logic [CharW-1:0] ChU     = "u";

  typedef enum logic [1:0] {
    ACT_FEED,
    ACT_READ,
    ACT_RESTART,
    ACT_HOLD
  } act_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_ROW
  } phase_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PUT,
    OP_BOL,
    OP_CLEAR,
    OP_DOWN,
    OP_UP,
    OP_LEFT,
    OP_RIGHT,
    OP_ERASE,
    OP_HOME,
    OP_INS,
    OP_OVR,
    OP_GOTO,
    OP_READ,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CharW-1:0]  ch;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } cmd_t;

  function automatic logic [CoordW-1:0] sat_coord(logic [CoordW-1:0] v,
                                                  logic [CoordW-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* src/tcss_front.sv */
// ----------------------------------------------------------------------------
// tcss_front: input word classifier and escape parser
// Accepts input words, tracks escape sequences and emits one command per
// accepted word.
// ----------------------------------------------------------------------------
module tcss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [tcss_pkg::CharW-1:0]    char_code_i,
  input  logic                          line_end_i,
  input  logic [tcss_pkg::CoordW-1:0]   read_row_i,
  input  logic [tcss_pkg::CoordW-1:0]   read_col_i,
  input  logic                          full_i,
  output logic                          push_o,
  output tcss_pkg::cmd_t                cmd_o
);
  import tcss_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CoordW-1:0] pending_q, pending_d;
  logic              accept;
  logic              is_digit;
  logic [CharW-1:0]  digit_full;
  logic [CoordW-1:0] digit;
  act_e              act;

  assign act        = act_e'(action_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign is_digit   = (char_code_i >= ChZero) && (char_code_i <= ChZero + 8'd9);
  assign digit_full = char_code_i - ChZero;
  assign digit      = digit_full[CoordW-1:0];

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    if (accept) begin
      case (act)
        ACT_FEED: begin
          case (phase_q)
            PH_IDLE: begin
              if (char_code_i == ChEsc) phase_d = PH_ESC;
            end
            PH_ESC: begin
              if (is_digit) begin
                phase_d   = PH_ROW;
                pending_d = digit;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
          if (line_end_i) phase_d = PH_IDLE;
        end
        ACT_RESTART: begin
          phase_d   = PH_IDLE;
          pending_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = OP_NOP;
    cmd_o.ch  = char_code_i;
    case (act)
      ACT_FEED: begin
        case (phase_q)
          PH_IDLE: begin
            if (char_code_i != ChEsc) cmd_o.op = OP_PUT;
          end
          PH_ESC: begin
            if (!is_digit) begin
              case (char_code_i)
                ChB:     cmd_o.op = OP_BOL;
                ChC:     cmd_o.op = OP_CLEAR;
                ChD:     cmd_o.op = OP_DOWN;
                ChU:     cmd_o.op = OP_UP;
                ChL:     cmd_o.op = OP_LEFT;
                ChR:     cmd_o.op = OP_RIGHT;
                ChE:     cmd_o.op = OP_ERASE;
                ChH:     cmd_o.op = OP_HOME;
                ChI:     cmd_o.op = OP_INS;
                ChO:     cmd_o.op = OP_OVR;
                ChEsc:   cmd_o.op = OP_PUT;
                default: cmd_o.op = OP_NOP;
              endcase
            end
          end
          PH_ROW: begin
            if (is_digit) begin
              cmd_o.op  = OP_GOTO;
              cmd_o.row = sat_coord(pending_q, RowMax);
              cmd_o.col = sat_coord(digit, ColMax);
            end
          end
          default: cmd_o.op = OP_NOP;
        endcase
      end
      ACT_READ: begin
        cmd_o.op  = OP_READ;
        cmd_o.row = read_row_i;
        cmd_o.col = read_col_i;
      end
      ACT_RESTART: cmd_o.op = OP_RESTART;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pending_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

endmodule

/* src/tcss_fifo.sv */
// ----------------------------------------------------------------------------
// tcss_fifo: command queue between front and back end
// Short first-in first-out buffer of command words.
// ----------------------------------------------------------------------------
module tcss_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcss_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcss_pkg::cmd_t cmd_o
);
  import tcss_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/tcss_back.sv */
// ----------------------------------------------------------------------------
// tcss_back: command executor and screen store
// Applies commands to the screen registers, cursor and mode, and holds the
// result word until it is taken.
// ----------------------------------------------------------------------------
module tcss_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  tcss_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tcss_pkg::CharW-1:0]  cell_char_o,
  output logic [tcss_pkg::CoordW-1:0] cursor_row_o,
  output logic [tcss_pkg::CoordW-1:0] cursor_col_o,
  output logic                        overwrite_on_o
);
  import tcss_pkg::*;

  logic [CharW-1:0]  scr_q [Rows][Cols];
  logic [CharW-1:0]  scr_d [Rows][Cols];
  logic [CoordW-1:0] row_q, row_d, col_q, col_d;
  logic              ovr_q, ovr_d;
  logic              valid_q, valid_d;
  logic [CharW-1:0]  cell_q, cell_d;
  logic              rd_hit;

  assign pop_o          = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o    = valid_q;
  assign cell_char_o    = cell_q;
  assign cursor_row_o   = row_q;
  assign cursor_col_o   = col_q;
  assign overwrite_on_o = ovr_q;
  assign rd_hit         = (cmd_i.row < CoordW'(Rows)) && (cmd_i.col < CoordW'(Cols));

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    ovr_d   = ovr_q;
    cell_d  = cell_q;
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (pop_o) begin
      valid_d = 1'b1;
      cell_d  = '0;
      case (cmd_i.op)
        OP_PUT:   if (col_q < ColMax) col_d = col_q + 1'b1;
        OP_BOL:   col_d = '0;
        OP_DOWN:  if (row_q < RowMax) row_d = row_q + 1'b1;
        OP_UP:    if (row_q != '0) row_d = row_q - 1'b1;
        OP_LEFT:  if (col_q != '0) col_d = col_q - 1'b1;
        OP_RIGHT: if (col_q < ColMax) col_d = col_q + 1'b1;
        OP_HOME: begin
          row_d = '0;
          col_d = '0;
        end
        OP_INS:   ovr_d = 1'b0;
        OP_OVR:   ovr_d = 1'b1;
        OP_GOTO: begin
          row_d = cmd_i.row;
          col_d = cmd_i.col;
        end
        OP_READ: begin
          if (rd_hit) cell_d = scr_q[cmd_i.row[RowIdxW-1:0]][cmd_i.col[ColIdxW-1:0]];
        end
        OP_RESTART: begin
          row_d = '0;
          col_d = '0;
          ovr_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < Rows; r++) begin : g_row
    for (genvar c = 0; c < Cols; c++) begin : g_col
      logic [CharW-1:0] left;
      logic             sel_row;
      logic [CoordW-1:0] ci;

      if (c == 0) begin : g_first
        assign left = scr_q[r][c];
      end else begin : g_rest
        assign left = scr_q[r][c-1];
      end

      assign sel_row = (row_q == CoordW'(r));
      assign ci      = CoordW'(c);

      always_comb begin
        scr_d[r][c] = scr_q[r][c];
        if (pop_o) begin
          case (cmd_i.op)
            OP_CLEAR, OP_RESTART: scr_d[r][c] = ChSpace;
            OP_PUT: begin
              if (sel_row) begin
                if (ci == col_q) begin
                  scr_d[r][c] = cmd_i.ch;
                end else if (!ovr_q && (ci > col_q)) begin
                  scr_d[r][c] = left;
                end
              end
            end
            OP_ERASE: begin
              if (sel_row && (ci >= col_q)) scr_d[r][c] = ChSpace;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      ovr_q   <= 1'b1;
      valid_q <= 1'b0;
      for (int r = 0; r < Rows; r++) begin
        for (int c = 0; c < Cols; c++) begin
          scr_q[r][c] <= ChSpace;
        end
      end
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      ovr_q   <= ovr_d;
      valid_q <= valid_d;
      scr_q   <= scr_d;
    end
  end

endmodule

/* src/terminal_control_sequence_screen.sv */
// ----------------------------------------------------------------------------
// terminal_control_sequence_screen: text screen with escape interpreter
// Front end parses the character stream into commands, a two-word queue
// decouples it from the back end that updates screen, cursor and mode.
//
//   port group  | direction | payload
//   s_axis      | in        | tuser action, tdata char/read row/read col,
//               |           | tlast line end
//   m_axis      | out       | tdata cell char, cursor row/col, overwrite
//
// One word per cycle sustained while the output is not stalled; each word
// is registered in the queue, then in the back end result register.
// Screen edits (shift, erase, clear) finish in the cycle the command is
// executed, across the register array. Reset fills the screen with spaces
// in the same cycle. A stalled output holds the back end; the queue takes
// up to two more words before the input stalls.
// ----------------------------------------------------------------------------
module terminal_control_sequence_screen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] char_code, [11:8] read_row, [15:12] read_col
  input  logic [tcss_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] cell_char, [11:8] cursor_row, [15:12] cursor_col, [16] overwrite_on
  output logic [tcss_pkg::OutDataW-1:0]   m_axis_tdata
);
  import tcss_pkg::*;

  cmd_t              push_cmd, pop_cmd;
  logic              push, pop, full, empty;
  logic [CharW-1:0]  cell_char;
  logic [CoordW-1:0] cursor_row, cursor_col;
  logic              overwrite_on;

  tcss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .char_code_i (s_axis_tdata[7:0]),
    .line_end_i  (s_axis_tlast),
    .read_row_i  (s_axis_tdata[11:8]),
    .read_col_i  (s_axis_tdata[15:12]),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tcss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  tcss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .cmd_i          (pop_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .cell_char_o    (cell_char),
    .cursor_row_o   (cursor_row),
    .cursor_col_o   (cursor_col),
    .overwrite_on_o (overwrite_on)
  );

  assign m_axis_tdata = {7'b0, overwrite_on, cursor_col, cursor_row, cell_char};

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cursor_row <= RowMax))
    else $error("cursor row beyond screen");

  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cursor_col <= ColMax))
    else $error("cursor column beyond screen");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (pop_cmd.op == OP_RESTART)) |=>
      (m_axis_tvalid && (cell_char == '0) && (cursor_row == '0) &&
       (cursor_col == '0) && overwrite_on))
    else $error("restart did not home cursor and set overwrite mode");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> !empty)
    else $error("queue lost a pushed command");

endmodule
